// ===== rtl/ssq_fit_pkg.sv =====
// Shared constants, state encoding and lane control type for the sin-squared fit.
`timescale 1ns / 1ps

package ssq_fit_pkg;

   // Default sizing
   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int SINE_DEPTH_DEF  = 1024;

   // Field widths
   localparam int TIME_W   = 16;
   localparam int READ_W   = 12;
   localparam int PHASE_W  = 32;
   localparam int REGR_W   = 16;
   localparam int COEF_W   = 40;
   localparam int CHANNELS = 4;

   // Fixed-point scaling of the two coefficients
   localparam int GAIN_SHIFT   = 32;
   localparam int OFFSET_SHIFT = 16;

   // Sine table generation constants (Q2.30)
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REGR,
      ST_ACCUM,
      ST_MUL,
      ST_DET,
      ST_START,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Control from the sequencer to each channel lane
   typedef struct packed {
      logic clear;
      logic accum;
      logic mul;
      logic diff;
      logic start;
   } lane_ctl_type;

endpackage

// ===== rtl/ssq_fit_regressor.sv =====
// Four-stage pipeline forming a = sin^2(phase) from a quarter-wave sine ROM.
`timescale 1ns / 1ps

module ssq_fit_regressor #(
   parameter int SINE_TABLE_DEPTH = ssq_fit_pkg::SINE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ssq_fit_pkg::PHASE_W-1:0]     phase_rate,
   input  logic [ssq_fit_pkg::TIME_W-1:0]      time_stamp,
   output logic                                a_valid,
   output logic [ssq_fit_pkg::REGR_W-1:0]      a
);

   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int FRAC_W  = 30;
   localparam int KPROD_W = FRAC_W + IDX_W + 1;
   localparam int PFULL_W = ssq_fit_pkg::PHASE_W + ssq_fit_pkg::TIME_W;

   typedef logic [15:0] rom_type [SINE_TABLE_DEPTH];

   // Q2.30 Horner series for sin at the center of table entry k, rounded to Q0.16
   function automatic logic [15:0] sine_entry(input int unsigned k);
      logic [63:0] u;
      logic [63:0] theta;
      logic [63:0] t2;
      logic [63:0] r;
      logic [63:0] s;
      u = (64'(2 * k + 1) << 31) / 64'(SINE_TABLE_DEPTH);
      theta = (u * ssq_fit_pkg::HALF_PI_Q30) >> 32;
      t2 = (theta * theta) >> 30;
      r = ssq_fit_pkg::Q30_ONE;
      r = ssq_fit_pkg::Q30_ONE - (((t2 * r) >> 30) / 64'd110);
      r = ssq_fit_pkg::Q30_ONE - (((t2 * r) >> 30) / 64'd72);
      r = ssq_fit_pkg::Q30_ONE - (((t2 * r) >> 30) / 64'd42);
      r = ssq_fit_pkg::Q30_ONE - (((t2 * r) >> 30) / 64'd20);
      r = ssq_fit_pkg::Q30_ONE - (((t2 * r) >> 30) / 64'd6);
      s = (theta * r) >> 30;
      s = (s + 64'd8192) >> 14;
      return (s > 64'd65535) ? 16'hFFFF : s[15:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type tbl;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         tbl[i] = sine_entry(i);
      end
      return tbl;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [3:0]                 vld_ff, vld_in;
   logic [31:0]                p_ff, p_in;
   logic [IDX_W-1:0]           k_ff, k_in;
   logic [15:0]                s_ff, s_in;
   logic [ssq_fit_pkg::REGR_W-1:0] a_ff, a_in;

   logic [PFULL_W-1:0]         pfull;
   logic [KPROD_W-1:0]         kprod;
   logic [IDX_W-1:0]           kraw;
   logic [31:0]                sq;
   logic [32:0]                sq_rnd;

   // Stage logic: phase, table index with quadrant fold, ROM read, square
   // Each stage loads only with its valid bit, so a holds until the next sample
   always_comb begin
      vld_in = {vld_ff[2:0], start};
      pfull  = PFULL_W'(phase_rate) * PFULL_W'(time_stamp);
      p_in   = start ? pfull[31:0] : p_ff;
      kprod  = KPROD_W'(p_ff[FRAC_W-1:0]) * KPROD_W'(SINE_TABLE_DEPTH);
      kraw   = kprod[FRAC_W +: IDX_W];
      k_in   = k_ff;
      if (vld_ff[0]) begin
         k_in = p_ff[FRAC_W] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - kraw) : kraw;
      end
      s_in   = vld_ff[1] ? SINE_ROM[k_ff] : s_ff;
      sq     = 32'(s_ff) * 32'(s_ff);
      sq_rnd = 33'(sq) + 33'd32768;
      a_in   = vld_ff[2] ? sq_rnd[31:16] : a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      k_ff <= k_in;
      s_ff <= s_in;
      a_ff <= a_in;
   end

   assign a_valid = vld_ff[3];
   assign a       = a_ff;

endmodule

// ===== rtl/ssq_fit_divider.sv =====
// Restoring divider giving one rounded, saturated signed coefficient with SHIFT fraction bits (Q24.16 at the default).
`timescale 1ns / 1ps

module ssq_fit_divider #(
   parameter int MAG_W = 64,
   parameter int DET_W = 53,
   parameter int SHIFT = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    neg,
   input  logic [MAG_W-1:0]                        mag,
   input  logic [DET_W-1:0]                        det,
   output logic                                    busy,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]   coef
);

   localparam int CW    = ssq_fit_pkg::COEF_W;
   localparam int QB    = CW + 1;
   localparam int NA_W  = MAG_W + SHIFT + 1;
   localparam int N_W   = ((NA_W > DET_W) ? NA_W : DET_W) + 1;
   localparam int DS_W  = DET_W + QB;
   localparam int REM_W = (N_W > DS_W) ? N_W : DS_W;
   localparam int CNT_W = $clog2(QB + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] dsh_ff, dsh_in;
   logic [QB-1:0]    q_ff, q_in;
   logic             neg_ff, neg_in;

   logic [N_W-1:0]   num2;
   logic             ge;
   logic [CW-1:0]    limit;
   logic [CW-1:0]    mag_q;

   // Load 2*mag*2^SHIFT + det against 2*det, then one quotient bit a cycle
   always_comb begin
      num2    = (N_W'(mag) << (SHIFT + 1)) + N_W'(det);
      ge      = rem_ff >= dsh_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QB);
         rem_in  = REM_W'(num2);
         dsh_in  = REM_W'(det) << QB;
         q_in    = '0;
         neg_in  = neg;
      end else if (busy_ff) begin
         rem_in  = ge ? (rem_ff - dsh_ff) : rem_ff;
         q_in    = {q_ff[QB-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   // Saturate to the signed range, then apply the sign
   always_comb begin
      limit = neg_ff ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      mag_q = (q_ff[QB-1] || (q_ff[CW-1:0] > limit)) ? limit : q_ff[CW-1:0];
      coef  = signed'(neg_ff ? (CW'(0) - mag_q) : mag_q);
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/ssq_fit_lane.sv =====
// One channel lane: reading sums, numerator products and two coefficient dividers.
`timescale 1ns / 1ps

module ssq_fit_lane #(
   parameter int MAX_SAMPLES = ssq_fit_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  ssq_fit_pkg::lane_ctl_type                ctl,
   input  logic [ssq_fit_pkg::REGR_W-1:0]           a,
   input  logic [ssq_fit_pkg::READ_W-1:0]           reading,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]         n,
   input  logic [ssq_fit_pkg::REGR_W+$clog2(MAX_SAMPLES)-1:0]   sa,
   input  logic [2*ssq_fit_pkg::REGR_W+$clog2(MAX_SAMPLES)-1:0] saa,
   input  logic [2*ssq_fit_pkg::REGR_W+$clog2(MAX_SAMPLES)+$clog2(MAX_SAMPLES+1)-1:0] det,
   output logic                                     busy,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]    gain,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]    offset
);

   localparam int SB    = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SA_W  = ssq_fit_pkg::REGR_W + SB;
   localparam int SAA_W = 2 * ssq_fit_pkg::REGR_W + SB;
   localparam int SY_W  = ssq_fit_pkg::READ_W + SB;
   localparam int AY_W  = ssq_fit_pkg::REGR_W + ssq_fit_pkg::READ_W;
   localparam int SAY_W = AY_W + SB;
   localparam int DET_W = SAA_W + CNT_W;
   localparam int G1_W  = CNT_W + SAY_W;
   localparam int G2_W  = SA_W + SY_W;
   localparam int O1_W  = SAA_W + SY_W;
   localparam int O2_W  = SA_W + SAY_W;
   localparam int GM_W  = (G1_W > G2_W) ? G1_W : G2_W;
   localparam int OM_W  = (O1_W > O2_W) ? O1_W : O2_W;
   localparam int MAG_W = (GM_W > OM_W) ? GM_W : OM_W;

   logic [SY_W-1:0]  sy_ff, sy_in;
   logic [SAY_W-1:0] say_ff, say_in;
   logic [G1_W-1:0]  g1_ff, g1_in;
   logic [G2_W-1:0]  g2_ff, g2_in;
   logic [O1_W-1:0]  o1_ff, o1_in;
   logic [O2_W-1:0]  o2_ff, o2_in;
   logic             gneg_ff, gneg_in;
   logic             oneg_ff, oneg_in;
   logic [MAG_W-1:0] gmag_ff, gmag_in;
   logic [MAG_W-1:0] omag_ff, omag_in;

   logic [AY_W-1:0]  ay;
   logic [MAG_W-1:0] g1x, g2x, o1x, o2x;
   logic             gain_busy, offset_busy;

   // Running sums of y and a*y
   always_comb begin
      ay     = AY_W'(a) * AY_W'(reading);
      sy_in  = sy_ff;
      say_in = say_ff;
      if (ctl.clear) begin
         sy_in  = '0;
         say_in = '0;
      end else if (ctl.accum) begin
         sy_in  = sy_ff + SY_W'(reading);
         say_in = say_ff + SAY_W'(ay);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sy_ff  <= '0;
         say_ff <= '0;
      end else begin
         sy_ff  <= sy_in;
         say_ff <= say_in;
      end
   end

   // Numerator products, then sign and magnitude of the differences
   always_comb begin
      g1_in   = ctl.mul ? (G1_W'(n) * G1_W'(say_ff)) : g1_ff;
      g2_in   = ctl.mul ? (G2_W'(sa) * G2_W'(sy_ff)) : g2_ff;
      o1_in   = ctl.mul ? (O1_W'(saa) * O1_W'(sy_ff)) : o1_ff;
      o2_in   = ctl.mul ? (O2_W'(sa) * O2_W'(say_ff)) : o2_ff;
      g1x     = MAG_W'(g1_ff);
      g2x     = MAG_W'(g2_ff);
      o1x     = MAG_W'(o1_ff);
      o2x     = MAG_W'(o2_ff);
      gneg_in = ctl.diff ? (g1x < g2x) : gneg_ff;
      oneg_in = ctl.diff ? (o1x < o2x) : oneg_ff;
      gmag_in = ctl.diff ? ((g1x < g2x) ? (g2x - g1x) : (g1x - g2x)) : gmag_ff;
      omag_in = ctl.diff ? ((o1x < o2x) ? (o2x - o1x) : (o1x - o2x)) : omag_ff;
   end

   always_ff @(posedge clock) begin
      g1_ff   <= g1_in;
      g2_ff   <= g2_in;
      o1_ff   <= o1_in;
      o2_ff   <= o2_in;
      gneg_ff <= gneg_in;
      oneg_ff <= oneg_in;
      gmag_ff <= gmag_in;
      omag_ff <= omag_in;
   end

   ssq_fit_divider #(
      .MAG_W (MAG_W),
      .DET_W (DET_W),
      .SHIFT (ssq_fit_pkg::GAIN_SHIFT)
   ) u_gain_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.start),
      .neg   (gneg_ff),
      .mag   (gmag_ff),
      .det   (det),
      .busy  (gain_busy),
      .coef  (gain)
   );

   ssq_fit_divider #(
      .MAG_W (MAG_W),
      .DET_W (DET_W),
      .SHIFT (ssq_fit_pkg::OFFSET_SHIFT)
   ) u_offset_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.start),
      .neg   (oneg_ff),
      .mag   (omag_ff),
      .det   (det),
      .busy  (offset_busy),
      .coef  (offset)
   );

   assign busy = gain_busy | offset_busy;

endmodule

// ===== rtl/sine_squared_least_squares_fit.sv =====
// Top level: sequencer, shared sums, determinant, four channel lanes and result register.
`timescale 1ns / 1ps
//
// Fits y = gain * sin^2(w*t) + offset on four sensor channels at once.
// req_ channel: one sample per transaction (time stamp, four readings,
// final_sample marker). csr_ channel: writes phase_rate (w, Q0.32 turns
// per tick); csr_ready is always high, write only while the block is idle.
// rsp_ channel: one transaction per final sample carrying four gains
// (signed Q8.32), four offsets (signed Q24.16) and fit_singular.
// After acceptance, req_ready stays low while the sample passes the
// four-stage regressor pipeline (phase multiply, table index, sine ROM,
// square) and the accumulate step. A final sample adds the solve: the
// product step, the difference step and a start step, then the dividers
// of all lanes form their 41 quotient bits in parallel, and the emit step
// loads the result register. The result register lets the next sample
// enter while the result waits; if rsp_ready stays low, a second solve
// holds in its last step until the register frees up. Synchronous reset
// clears phase_rate, all sums and the result valid.

module sine_squared_least_squares_fit #(
   parameter int MAX_SAMPLES      = ssq_fit_pkg::MAX_SAMPLES_DEF,
   parameter int SINE_TABLE_DEPTH = ssq_fit_pkg::SINE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ssq_fit_pkg::TIME_W-1:0]         req_time_stamp,
   input  logic [ssq_fit_pkg::READ_W-1:0]         req_reading_one,
   input  logic [ssq_fit_pkg::READ_W-1:0]         req_reading_two,
   input  logic [ssq_fit_pkg::READ_W-1:0]         req_reading_three,
   input  logic [ssq_fit_pkg::READ_W-1:0]         req_reading_four,
   input  logic                                   req_final_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]  rsp_gain_one,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]  rsp_offset_one,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]  rsp_gain_two,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]  rsp_offset_two,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]  rsp_gain_three,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]  rsp_offset_three,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]  rsp_gain_four,
   output logic signed [ssq_fit_pkg::COEF_W-1:0]  rsp_offset_four,
   output logic                                   rsp_fit_singular,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ssq_fit_pkg::PHASE_W-1:0]        csr_phase_rate
);

   localparam int NCH   = ssq_fit_pkg::CHANNELS;
   localparam int CW    = ssq_fit_pkg::COEF_W;
   localparam int RW    = ssq_fit_pkg::READ_W;
   localparam int SB    = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SA_W  = ssq_fit_pkg::REGR_W + SB;
   localparam int SAA_W = 2 * ssq_fit_pkg::REGR_W + SB;
   localparam int AA_W  = 2 * ssq_fit_pkg::REGR_W;
   localparam int P_W   = SAA_W + CNT_W;
   localparam int Q_W   = 2 * SA_W;
   localparam int CMP_W = (P_W > Q_W) ? P_W : Q_W;

   ssq_fit_pkg::state_type   state_ff, state_in;
   ssq_fit_pkg::lane_ctl_type ctl;

   logic [ssq_fit_pkg::PHASE_W-1:0] phase_rate_ff, phase_rate_in;
   logic [RW-1:0]    reading_ff [NCH];
   logic [RW-1:0]    reading_in [NCH];
   logic             final_ff, final_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [SA_W-1:0]  sa_ff, sa_in;
   logic [SAA_W-1:0] saa_ff, saa_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [P_W-1:0]   det_ff, det_in;
   logic             singular_ff, singular_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0] gain_ff [NCH];
   logic signed [CW-1:0] gain_in [NCH];
   logic signed [CW-1:0] offset_ff [NCH];
   logic signed [CW-1:0] offset_in [NCH];
   logic             fit_singular_ff, fit_singular_in;

   logic             accept;
   logic             reg_start;
   logic             a_valid;
   logic [ssq_fit_pkg::REGR_W-1:0] a;
   logic [AA_W-1:0]  aa;
   logic             do_accum;
   logic             slot_free;
   logic             emit_load;
   logic [NCH-1:0]   lane_busy;
   logic signed [CW-1:0] lane_gain [NCH];
   logic signed [CW-1:0] lane_offset [NCH];

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssq_fit_pkg::ST_IDLE:  if (req_valid) state_in = ssq_fit_pkg::ST_REGR;
         ssq_fit_pkg::ST_REGR:  if (a_valid) state_in = ssq_fit_pkg::ST_ACCUM;
         ssq_fit_pkg::ST_ACCUM: begin
            state_in = final_ff ? ssq_fit_pkg::ST_MUL : ssq_fit_pkg::ST_IDLE;
         end
         ssq_fit_pkg::ST_MUL:   state_in = ssq_fit_pkg::ST_DET;
         ssq_fit_pkg::ST_DET:   state_in = ssq_fit_pkg::ST_START;
         ssq_fit_pkg::ST_START: state_in = ssq_fit_pkg::ST_DIV;
         ssq_fit_pkg::ST_DIV:   if (!(|lane_busy)) state_in = ssq_fit_pkg::ST_EMIT;
         ssq_fit_pkg::ST_EMIT:  if (slot_free) state_in = ssq_fit_pkg::ST_IDLE;
         default:               state_in = ssq_fit_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      do_accum  = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         ssq_fit_pkg::ST_IDLE:  req_ready = 1'b1;
         ssq_fit_pkg::ST_ACCUM: begin
            do_accum  = (n_ff < CNT_W'(MAX_SAMPLES));
            ctl.accum = do_accum;
         end
         ssq_fit_pkg::ST_MUL:   ctl.mul = 1'b1;
         ssq_fit_pkg::ST_DET:   ctl.diff = 1'b1;
         ssq_fit_pkg::ST_START: ctl.start = 1'b1;
         ssq_fit_pkg::ST_EMIT: begin
            emit_load = slot_free;
            ctl.clear = slot_free;
         end
         default: ;
      endcase
   end

   assign reg_start = accept;

   // Configuration, sample capture and shared sums
   always_comb begin
      phase_rate_in = (csr_valid && csr_ready) ? csr_phase_rate : phase_rate_ff;
      final_in      = accept ? req_final_sample : final_ff;
      reading_in[0] = accept ? req_reading_one   : reading_ff[0];
      reading_in[1] = accept ? req_reading_two   : reading_ff[1];
      reading_in[2] = accept ? req_reading_three : reading_ff[2];
      reading_in[3] = accept ? req_reading_four  : reading_ff[3];
      aa     = AA_W'(a) * AA_W'(a);
      n_in   = n_ff;
      sa_in  = sa_ff;
      saa_in = saa_ff;
      if (emit_load) begin
         n_in   = '0;
         sa_in  = '0;
         saa_in = '0;
      end else if (do_accum) begin
         n_in   = n_ff + CNT_W'(1);
         sa_in  = sa_ff + SA_W'(a);
         saa_in = saa_ff + SAA_W'(aa);
      end
   end

   // Determinant n*sum(a^2) - sum(a)^2 and singular test
   always_comb begin
      p_in        = ctl.mul ? (P_W'(saa_ff) * P_W'(n_ff)) : p_ff;
      q_in        = ctl.mul ? (Q_W'(sa_ff) * Q_W'(sa_ff)) : q_ff;
      det_in      = ctl.diff ? P_W'(CMP_W'(p_ff) - CMP_W'(q_ff)) : det_ff;
      singular_in = ctl.diff ? ((n_ff < CNT_W'(2)) || (CMP_W'(p_ff) <= CMP_W'(q_ff)))
                             : singular_ff;
   end

   // Result register
   always_comb begin
      rsp_valid_in    = emit_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      fit_singular_in = emit_load ? singular_ff : fit_singular_ff;
      for (int i = 0; i < NCH; i++) begin
         gain_in[i]   = gain_ff[i];
         offset_in[i] = offset_ff[i];
         if (emit_load) begin
            gain_in[i]   = singular_ff ? '0 : lane_gain[i];
            offset_in[i] = singular_ff ? '0 : lane_offset[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ssq_fit_pkg::ST_IDLE;
         phase_rate_ff <= '0;
         n_ff          <= '0;
         sa_ff         <= '0;
         saa_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_rate_ff <= phase_rate_in;
         n_ff          <= n_in;
         sa_ff         <= sa_in;
         saa_ff        <= saa_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff        <= final_in;
      p_ff            <= p_in;
      q_ff            <= q_in;
      det_ff          <= det_in;
      singular_ff     <= singular_in;
      fit_singular_ff <= fit_singular_in;
      for (int i = 0; i < NCH; i++) begin
         reading_ff[i] <= reading_in[i];
         gain_ff[i]    <= gain_in[i];
         offset_ff[i]  <= offset_in[i];
      end
   end

   ssq_fit_regressor #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_regressor (
      .clock      (clock),
      .reset      (reset),
      .start      (reg_start),
      .phase_rate (phase_rate_ff),
      .time_stamp (req_time_stamp),
      .a_valid    (a_valid),
      .a          (a)
   );

   // Channel lanes
   for (genvar g = 0; g < NCH; g++) begin : g_lane
      ssq_fit_lane #(
         .MAX_SAMPLES (MAX_SAMPLES)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .a       (a),
         .reading (reading_ff[g]),
         .n       (n_ff),
         .sa      (sa_ff),
         .saa     (saa_ff),
         .det     (det_ff),
         .busy    (lane_busy[g]),
         .gain    (lane_gain[g]),
         .offset  (lane_offset[g])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fit_singular = fit_singular_ff;
   assign rsp_gain_one     = gain_ff[0];
   assign rsp_offset_one   = offset_ff[0];
   assign rsp_gain_two     = gain_ff[1];
   assign rsp_offset_two   = offset_ff[1];
   assign rsp_gain_three   = gain_ff[2];
   assign rsp_offset_three = offset_ff[2];
   assign rsp_gain_four    = gain_ff[3];
   assign rsp_offset_four  = offset_ff[3];

   // Checks
   a_accept_lanes_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(|lane_busy))
      else $error("sample accepted while a solve is running");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ssq_fit_pkg::ST_EMIT))
      else $error("result raised outside the emit step");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && fit_singular_ff) |->
         (gain_ff[0] == '0 && offset_ff[0] == '0 && gain_ff[1] == '0 &&
          offset_ff[1] == '0 && gain_ff[2] == '0 && offset_ff[2] == '0 &&
          gain_ff[3] == '0 && offset_ff[3] == '0))
      else $error("singular fit with nonzero coefficients");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count above limit");

   a_busy_in_div: assert property (@(posedge clock) disable iff (reset)
      (|lane_busy) |-> (state_ff == ssq_fit_pkg::ST_DIV))
      else $error("divider running outside the divide step");

endmodule
